FILE: hdl/fsc_pkg.sv
// Package for the fuzzy speed controller: payload types, register codes, constants.
package fsc_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TARGET    = 3'd0,
        REG_EGAIN     = 3'd1,
        REG_DEGAIN    = 3'd2,
        REG_OGAIN     = 3'd3,
        REG_PERIOD    = 3'd4,
        REG_FLOOR     = 3'd5,
        REG_CEIL      = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic signed [15:0] measured_speed;
        logic               motor_direction;
    } t_in_req;

    typedef struct packed {
        logic [15:0] duty_out;
        logic        pwm_stopped;
        logic        drive_direction;
    } t_out_req;

    // divider operation request
    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [31:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [63:0] quotient;
    } t_div_rsp;

    localparam logic signed [8:0] GRADE_FULL = 9'sd100;

    // 100*k/span for the spans in use (40, 60, 100); k < span.
    // 1/3 as 171/512 is exact for 5*k below 300.
    function automatic logic [6:0] span_grade(input logic [6:0] k,
                                              input logic [6:0] span);
        logic [9:0]  k5;
        logic [18:0] p;
        logic [6:0]  r;
        k5 = 10'(k) * 10'd5;
        p  = 19'(k5) * 19'd171;
        unique case (span)
            7'd40:   r = 7'(k5 >> 1);
            7'd60:   r = p[15:9];
            default: r = k;
        endcase
        return r;
    endfunction

    // Trapezoid membership grade; x in -100..100, all breakpoints constant.
    function automatic logic [6:0] trap(input logic signed [8:0] x,
                                        input logic signed [8:0] a,
                                        input logic signed [8:0] b,
                                        input logic signed [8:0] c,
                                        input logic signed [8:0] d);
        logic [6:0] r;
        if (x < a) r = 7'd0;
        else if (x < b) r = span_grade(7'(x - a), 7'(b - a));
        else if (x < c) r = 7'd100;
        else if (x < d) r = span_grade(7'(d - x), 7'(d - c));
        else r = 7'd0;
        return r;
    endfunction

endpackage

FILE: hdl/fuzzy_speed_controller.sv
// Top level of the fuzzy PI speed controller.
//
//  channel  | signals                        | payload
//  in       | i_in_valid / o_in_ready        | t_in_req  (speed, direction)
//  out      | o_out_valid / i_out_ready      | t_out_req (duty, stopped, dir)
//  cfg      | i_cfg_we, i_cfg_idx, i_cfg_data| 32-bit write data
//
// A request makes three passes of the shared bit-serial divider (x1, de*100/period,
// x2), each an issue, 64 quotient steps and a take; then the 15 rules are summed,
// sum*period*gain is formed through r_sp and r_prod, and the output is registered.
// A zero error gain skips the first pass; a zero rate gain or period skips the other two.
// Reset is synchronous active low and restores the state, loop and config registers only.
// The result sits in an output register; the input stays closed until it is taken.
module fuzzy_speed_controller
    import fsc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_req               i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_req              o_out_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);
    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001, S_D1 = 9'b000000010, S_W1 = 9'b000000100,
        S_D2   = 9'b000001000, S_W2 = 9'b000010000, S_D3 = 9'b000100000,
        S_W3   = 9'b001000000, S_RULE = 9'b010000000, S_OUT = 9'b100000000
    } t_state;

    t_state r_state, n_state;

    // configuration
    logic signed [15:0] r_target;
    logic [31:0] r_egain, r_degain, r_ogain;
    logic [9:0]  r_period;
    logic [15:0] r_floor, r_ceil;

    // loop state
    logic signed [17:0] r_last_err, n_last_err;
    logic [15:0] r_duty, n_duty;

    // work registers
    logic signed [17:0] r_err, n_err, r_derr, n_derr;
    logic        r_dir, n_dir;
    logic signed [8:0] r_x1, n_x1, r_x2, n_x2;
    logic signed [63:0] r_q, n_q;      // magnitude of de*100/period; sign in r_neg
    logic signed [10:0] r_sum, n_sum;  // rule sum, |sum| <= 900
    logic [3:0]  r_rule, n_rule;
    logic        r_ovalid, n_ovalid;
    t_out_req    r_out, n_out;

    t_div_req div_req;
    t_div_rsp div_rsp;

    fsc_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(div_req), .o_rsp(div_rsp));

    // magnitude and sign of the current dividend
    logic        neg;
    logic [63:0] mag, qs;
    logic signed [64:0] sq;
    logic signed [8:0] clamped;

    // memberships
    logic [6:0] es [5];
    logic [6:0] ds [3];
    logic [6:0] mn;
    logic signed [2:0] w;
    logic [1:0] rj_i;
    logic [2:0] ei;
    logic [8:0] rmul;

    // final product: sum*period*gain, done in stages via registers
    logic signed [21:0] r_sp, n_sp;    // sum*period
    logic signed [54:0] r_prod;        // sum*period*gain
    logic signed [54:0] n_prod;
    logic signed [38:0] inc;
    logic signed [39:0] nxt;
    logic [1:0] r_tail, n_tail;

    always_comb begin
        es[0] = trap(r_x1, -9'sd200, -9'sd100, -9'sd100, -9'sd40);
        es[1] = trap(r_x1, -9'sd100, -9'sd40, -9'sd40, 9'sd0);
        es[2] = trap(r_x1, -9'sd40, 9'sd0, 9'sd0, 9'sd40);
        es[3] = trap(r_x1, 9'sd0, 9'sd40, 9'sd40, 9'sd100);
        es[4] = trap(r_x1, 9'sd40, 9'sd100, 9'sd100, 9'sd200);
        ds[0] = trap(r_x2, -9'sd200, -9'sd100, -9'sd100, 9'sd0);
        ds[1] = trap(r_x2, -9'sd100, 9'sd0, 9'sd0, 9'sd100);
        ds[2] = trap(r_x2, 9'sd0, 9'sd100, 9'sd100, 9'sd200);
    end

    // rule row = rule/3 as rule*11/32 (exact for 0..15), column is the rest
    always_comb begin
        rmul = 9'(r_rule) * 9'd11;
        ei = rmul[7:5];
        rj_i = 2'(r_rule - 4'(ei) * 4'd3);
        mn = (es[ei] < ds[rj_i]) ? es[ei] : ds[rj_i];
        w = 3'(signed'({1'b0, ei}) + signed'({1'b0, rj_i}) - 4'sd3);
    end

    // signed result of the last division
    always_comb begin
        qs = div_rsp.quotient;
        sq = neg ? -$signed({1'b0, qs}) : $signed({1'b0, qs});
        if (sq > 65'sd100) clamped = GRADE_FULL;
        else if (sq < -65'sd100) clamped = -GRADE_FULL;
        else clamped = 9'(sq);
    end

    logic r_neg, n_neg;
    assign neg = r_neg;

    function automatic logic signed [8:0] sgn100(input logic signed [63:0] v);
        if (v > 0) return GRADE_FULL;
        else if (v < 0) return -GRADE_FULL;
        return 9'sd0;
    endfunction

    always_comb begin
        n_state = r_state; n_last_err = r_last_err; n_duty = r_duty;
        n_err = r_err; n_derr = r_derr; n_dir = r_dir; n_x1 = r_x1; n_x2 = r_x2;
        n_q = r_q; n_sum = r_sum; n_rule = r_rule; n_ovalid = r_ovalid;
        n_out = r_out; n_neg = r_neg; n_sp = r_sp; n_prod = r_prod; n_tail = r_tail;
        div_req = '0; mag = '0; inc = '0; nxt = '0;
        if (r_ovalid && i_out_ready) n_ovalid = 1'b0;
        unique case (r_state)
            S_IDLE: if (i_in_valid && !r_ovalid) begin
                n_err = 18'(r_target) - 18'(i_in_data.measured_speed);
                n_dir = i_in_data.motor_direction;
                n_state = S_D1;
            end
            S_D1: begin
                n_derr = r_err - r_last_err;
                n_last_err = r_err;
                if (r_egain == '0) begin
                    n_x1 = sgn100(64'(r_err));
                    n_state = S_D2;
                end else begin
                    mag = 64'(r_err[17] ? -r_err : r_err) * 64'd6553600;
                    n_neg = r_err[17];
                    div_req = '{start: 1'b1, dividend: mag, divisor: r_egain};
                    n_state = S_W1;
                end
            end
            S_W1: if (div_rsp.done) begin
                n_x1 = clamped; n_state = S_D2;
            end
            S_D2: begin
                if (r_degain == '0 || r_period == '0) begin
                    n_x2 = sgn100(64'(r_derr));
                    n_state = S_RULE; n_rule = '0; n_sum = '0; n_tail = '0;
                end else begin
                    mag = 64'(r_derr[17] ? -r_derr : r_derr) * 64'd100;
                    n_neg = r_derr[17];
                    div_req = '{start: 1'b1, dividend: mag, divisor: 32'(r_period)};
                    n_state = S_W2;
                end
            end
            S_W2: if (div_rsp.done) begin
                n_q = 64'(qs); n_state = S_D3;   // magnitude; sign kept in r_neg
            end
            S_D3: begin
                div_req = '{start: 1'b1, dividend: {r_q[47:0], 16'd0}, divisor: r_degain};
                n_state = S_W3;
            end
            S_W3: if (div_rsp.done) begin
                n_x2 = clamped; n_state = S_RULE; n_rule = '0; n_sum = '0; n_tail = '0;
            end
            S_RULE: begin
                if (r_rule < 4'd15) begin
                    n_sum = r_sum + 11'(w) * 11'(signed'({1'b0, mn}));
                    n_rule = r_rule + 4'd1;
                end else begin
                    unique case (r_tail)
                        2'd0: begin
                            n_sp = 22'(r_sum) * signed'({12'd0, r_period});
                            n_tail = 2'd1;
                        end
                        2'd1: begin
                            n_prod = 55'(r_sp) * signed'({23'd0, r_ogain});
                            n_tail = 2'd2;
                        end
                        default: n_state = S_OUT;
                    endcase
                end
            end
            S_OUT: begin
                inc = 39'(r_prod / 55'sd65536);
                nxt = 40'(r_duty) + 40'(inc);
                if (nxt <= 0) begin
                    n_duty = '0;
                    n_out = '{duty_out: 16'd0, pwm_stopped: 1'b1, drive_direction: 1'b0};
                end else begin
                    if (nxt < 40'(r_floor)) n_duty = r_floor;
                    else if (nxt > 40'(r_ceil)) n_duty = r_ceil;
                    else n_duty = nxt[15:0];
                    n_out = '{duty_out: n_duty, pwm_stopped: 1'b0, drive_direction: r_dir};
                end
                n_ovalid = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_err <= n_err; r_derr <= n_derr; r_dir <= n_dir; r_x1 <= n_x1; r_x2 <= n_x2;
        r_q <= n_q; r_sum <= n_sum; r_rule <= n_rule; r_out <= n_out; r_neg <= n_neg;
        r_sp <= n_sp; r_prod <= n_prod; r_tail <= n_tail;
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_ovalid <= 1'b0;
            r_last_err <= '0; r_duty <= '0;
            r_target <= '0; r_egain <= 32'd65536; r_degain <= 32'd65536;
            r_ogain <= '0; r_period <= 10'd10; r_floor <= '0; r_ceil <= 16'hFFFF;
        end else begin
            r_state <= n_state; r_ovalid <= n_ovalid;
            r_last_err <= n_last_err; r_duty <= n_duty;
            if (i_cfg_we) begin
                unique case (t_reg_idx'(i_cfg_idx))
                    REG_TARGET: r_target <= i_cfg_data[15:0];
                    REG_EGAIN:  r_egain  <= i_cfg_data;
                    REG_DEGAIN: r_degain <= i_cfg_data;
                    REG_OGAIN:  r_ogain  <= i_cfg_data;
                    REG_PERIOD: r_period <= i_cfg_data[9:0];
                    REG_FLOOR:  r_floor  <= i_cfg_data[15:0];
                    REG_CEIL:   r_ceil   <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
        end
    end

    assign o_in_ready  = (r_state == S_IDLE) && !r_ovalid;
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

`ifndef ASSERT_OFF
    a_stop_dir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && r_out.pwm_stopped |-> !r_out.drive_direction && r_out.duty_out == 16'd0)
        else $error("stopped result malformed");
    a_busy_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_IDLE |-> !o_in_ready) else $error("ready while busy");
    a_duty_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> r_out.duty_out == r_duty) else $error("duty mismatch");
`endif
endmodule

FILE: hdl/fsc_div.sv
// Shared radix-2 unsigned divider, one quotient bit per cycle.
module fsc_div
    import fsc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);
    logic [63:0] r_q, n_q;
    logic [32:0] r_rem, n_rem;
    logic [31:0] r_den, n_den;
    logic [6:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy, r_done, n_done;
    logic [32:0] trial;

    always_comb begin
        n_q = r_q; n_rem = r_rem; n_den = r_den; n_cnt = r_cnt;
        n_busy = r_busy; n_done = 1'b0;
        trial = '0;
        if (i_req.start) begin
            n_q = i_req.dividend; n_rem = '0; n_den = i_req.divisor;
            n_cnt = 7'd0; n_busy = 1'b1;
        end else if (r_busy) begin
            trial = {r_rem[31:0], r_q[63]};
            n_q = {r_q[62:0], 1'b0};
            if (trial >= {1'b0, r_den}) begin
                n_rem = trial - {1'b0, r_den};
                n_q[0] = 1'b1;
            end else n_rem = trial;
            n_cnt = r_cnt + 7'd1;
            if (r_cnt == 7'd63) begin
                n_busy = 1'b0; n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q; r_rem <= n_rem; r_den <= n_den; r_cnt <= n_cnt;
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_done <= 1'b0;
        end else begin
            r_busy <= n_busy; r_done <= n_done;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quotient = r_q;

`ifndef ASSERT_OFF
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy)) else $error("done without busy");
    a_not_both: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_done && r_busy)) else $error("done while busy");
    a_cnt_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_busy) |-> r_cnt == 7'd0) else $error("count not cleared");
`endif
endmodule
